/* hw/rtl/sipq_pkg.sv */
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants of the sorted-insert priority queue: field
// widths, status codes and the entry and command words passed along the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

	localparam int KEY_W        = 31;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 5;
	localparam int CAPACITY_DEF = 16;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                     valid;
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] data;
	} entry_t;

	// push and pop are only raised for operations that change the queue
	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] data;
	} cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/sipq_cell.sv */
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted chain. On a push it keeps its entry, takes the one
// from its left neighbor or takes the new word; on a pop it takes the entry
// from its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sipq_pkg::cmd_t   cmd,
	input  wire sipq_pkg::entry_t left_ent,
	input  wire logic            left_disp,
	input  wire sipq_pkg::entry_t right_ent,
	output sipq_pkg::entry_t      ent,
	output logic                 disp
);

	logic                               valid_q;
	logic [sipq_pkg::KEY_W-1:0]         key_q;
	logic signed [sipq_pkg::DATA_W-1:0] data_q;
	sipq_pkg::entry_t                   nxt;
	logic                               load;

	assign ent = '{valid: valid_q, key: key_q, data: data_q};

	// empty slot or a larger key: this cell moves toward the tail on a push
	assign disp = !valid_q || (key_q > cmd.key);

	always_comb begin
		nxt  = ent;
		load = 1'b0;
		if (cmd.push) begin
			if (disp) begin
				load = 1'b1;
				if (left_disp) begin
					nxt = left_ent;
				end else begin
					nxt = '{valid: 1'b1, key: cmd.key, data: cmd.data};
				end
			end
		end else if (cmd.pop) begin
			load = 1'b1;
			nxt  = right_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q  <= nxt.key;
			data_q <= nxt.data;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sorted_insert_priority_queue.sv */
// Latency: the result word appears on the cycle after start is taken, marked by done.
// Throughput: one push or pop per cycle; busy stays low, and every cell updates at the same clock edge.
// The receiver cannot stall: done marks each result for exactly one cycle.
// Reset clears every cell's valid bit and the count; entry storage is not cleared.
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded priority queue held as a sorted chain of cells, smallest key at
// cell 0. Equal keys leave in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue #(
	parameter int CAPACITY = sipq_pkg::CAPACITY_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               operation,
	input  wire logic signed [sipq_pkg::DATA_W-1:0] data,
	input  wire logic [sipq_pkg::KEY_W-1:0]         key,
	output logic                                    done,
	output logic [1:0]                              status,
	output logic signed [sipq_pkg::DATA_W-1:0]      front_data,
	output logic [sipq_pkg::KEY_W-1:0]              front_key,
	output logic [sipq_pkg::COUNT_W-1:0]            count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	sipq_pkg::status_t  status_q;
	sipq_pkg::cmd_t     cmd;
	sipq_pkg::entry_t   ents [CAPACITY];
	logic               disps [CAPACITY];
	logic               accept;
	logic               full;
	logic               empty;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign empty  = (cnt_q == '0);

	assign cmd.push = accept && (operation == sipq_pkg::OP_PUSH) && !full;
	assign cmd.pop  = accept && (operation == sipq_pkg::OP_POP) && !empty;
	assign cmd.key  = key;
	assign cmd.data = data;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sipq_pkg::entry_t left_ent;
		sipq_pkg::entry_t right_ent;
		logic             left_disp;

		if (i == 0) begin : g_first
			assign left_ent  = '0;
			assign left_disp = 1'b0;
		end else begin : g_mid
			assign left_ent  = ents[i-1];
			assign left_disp = disps[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = ents[i+1];
		end

		sipq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_ent  (left_ent),
			.left_disp (left_disp),
			.right_ent (right_ent),
			.ent       (ents[i]),
			.disp      (disps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			done_q   <= 1'b0;
			status_q <= sipq_pkg::ST_DONE;
		end else begin
			done_q <= accept;
			if (cmd.push) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (accept) begin
				if (operation == sipq_pkg::OP_PUSH && full) begin
					status_q <= sipq_pkg::ST_FULL;
				end else if (operation == sipq_pkg::OP_POP && empty) begin
					status_q <= sipq_pkg::ST_EMPTY;
				end else begin
					status_q <= sipq_pkg::ST_DONE;
				end
			end
		end
	end

	// cell 0 already holds the front after the operation; zero it when empty
	assign done       = done_q;
	assign status     = status_q;
	assign front_data = ents[0].valid ? ents[0].data : '0;
	assign front_key  = ents[0].valid ? ents[0].key : '0;
	assign count      = sipq_pkg::COUNT_W'(cnt_q);

endmodule

`default_nettype wire
